/* rtl/amx_pkg.sv */
// Shared types, constants and helpers for the crosspoint audio mixer.
package amx_pkg;

  localparam int NUM_IN   = 8;
  localparam int NUM_OUT  = 8;
  localparam int MAX_GAIN = 16384;

  localparam int OUT_LIM  = (NUM_OUT < 8) ? NUM_OUT : 8;
  localparam int OUT_IW   = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
  localparam int CNT_W    = $clog2(OUT_LIM + 1);

  localparam logic [15:0] UNITY = 16'd4096;

  // settle-state length after the token leaves the last cell, so that its accumulator holds the result
  localparam int SETTLE_CYC = 4;
  localparam int SETTLE_W   = $clog2(SETTLE_CYC);

  // command codes
  localparam logic [2:0] CMD_SAMPLE   = 3'd0;
  localparam logic [2:0] CMD_XP       = 3'd1;
  localparam logic [2:0] CMD_IN_GAIN  = 3'd2;
  localparam logic [2:0] CMD_OUT_GAIN = 3'd3;
  localparam logic [2:0] CMD_IN_MUTE  = 3'd4;
  localparam logic [2:0] CMD_OUT_MUTE = 3'd5;
  localparam logic [2:0] CMD_SOLO     = 3'd6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_IN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         in_index;
    logic [2:0]         out_index;
    logic signed [23:0] sample;
    logic [15:0]        setting;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [23:0] out_sample;
    logic               last_output;
  } out_item_t;

  // sample token walking the cell row
  typedef struct packed {
    logic               valid;
    logic               mix;
    logic [2:0]         in_index;
    logic signed [23:0] sample;
    logic [15:0]        in_gain;
  } mix_tok_t;

  // settings write aimed at one cell
  typedef struct packed {
    logic        xp_we;
    logic        og_we;
    logic        mute_we;
    logic        solo_we;
    logic [2:0]  in_index;
    logic [15:0] gain;
    logic        flag;
  } cell_wr_t;

  function automatic logic [15:0] clamp_gain(input logic [15:0] v);
    logic [15:0] lim;
    lim = (MAX_GAIN > 65535) ? 16'hFFFF : 16'(MAX_GAIN);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* rtl/amx_cell.sv */
// One output cell: crosspoint column, output level, mute/solo, MAC and accumulator.
module amx_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  amx_pkg::mix_tok_t  tok_in,
  output amx_pkg::mix_tok_t  tok_out,
  input  amx_pkg::cell_wr_t  wr,
  input  logic               mix_en,
  input  logic [15:0]        thresh,
  input  logic               any_solo,
  input  logic               clr,
  output logic               solo,
  output logic signed [23:0] out_val
);

  logic [15:0]        xp_r [amx_pkg::NUM_IN];
  logic [15:0]        og_r;
  logic               mute_r;
  logic               solo_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] acc_nxt;

  amx_pkg::mix_tok_t  tok_r;

  logic               va_r, vb_r, vc_r, vd_r;
  logic signed [23:0] sa_r, sb_r, sc_r;
  logic [31:0]        p1_r;
  logic [47:0]        p2_r;
  logic [23:0]        g_r;
  logic signed [48:0] p3_r;

  logic [15:0]        xp_rd;
  logic               hit;
  logic [47:0]        g_rnd;
  logic signed [48:0] p3_rnd;
  logic signed [36:0] term37;
  logic signed [31:0] term32;
  logic signed [32:0] sum33;

  assign tok_out = tok_r;
  assign solo    = solo_r;

  assign xp_rd = xp_r[tok_in.in_index];
  assign hit   = tok_in.valid && tok_in.mix && mix_en && (xp_rd > thresh);
  assign g_rnd = p2_r + 48'h80_0000;

  always_comb begin
    p3_rnd = p3_r + 49'sd2048;
    term37 = p3_rnd[48:12];
    if (term37[36:31] == {6{term37[31]}}) begin
      term32 = term37[31:0];
    end else begin
      term32 = term37[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    sum33 = {acc_r[31], acc_r} + {term32[31], term32};
    if (sum33[32] == sum33[31]) begin
      acc_nxt = sum33[31:0];
    end else begin
      acc_nxt = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // saturated to 24 bits, silent when muted or left out of the solo set
  always_comb begin
    if (mute_r || (any_solo && !solo_r)) begin
      out_val = '0;
    end else if (acc_r[31:23] == {9{acc_r[23]}}) begin
      out_val = acc_r[23:0];
    end else begin
      out_val = acc_r[31] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < amx_pkg::NUM_IN; i++) begin
        xp_r[i] <= '0;
      end
      og_r   <= amx_pkg::UNITY;
      mute_r <= 1'b0;
      solo_r <= 1'b0;
    end else begin
      if (wr.xp_we) begin
        xp_r[wr.in_index] <= wr.gain;
      end
      if (wr.og_we) begin
        og_r <= wr.gain;
      end
      if (wr.mute_we) begin
        mute_r <= wr.flag;
      end
      if (wr.solo_we) begin
        solo_r <= wr.flag;
      end
    end
  end

  // MAC pipeline: xp*ig, *og, round to Q.12, *sample, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      vd_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      tok_r <= tok_in;
      va_r  <= hit;
      vb_r  <= va_r;
      vc_r  <= vb_r;
      vd_r  <= vc_r;
      if (clr) begin
        acc_r <= '0;
      end else if (vd_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= 32'(xp_rd) * 32'(tok_in.in_gain);
    sa_r <= tok_in.sample;
    p2_r <= 48'(p1_r) * 48'(og_r);
    sb_r <= sa_r;
    g_r  <= g_rnd[47:24];
    sc_r <= sb_r;
    p3_r <= 49'(sc_r) * $signed({25'd0, g_r});
  end

endmodule

/* rtl/audio_matrix_mixer.sv */
// Top level of the crosspoint audio mixer: command decode, cell row and frame readout.
// Input hold: a command item leaves the input ready; a sample item holds the input while
//   its token walks the row of output cells and then the multiply chain inside the last
//   cell settles.
// Flow: one sample item at a time; a frame-end sample also holds the input while the
//   used outputs are read out, stalls included. The output register frees the input side.
// Reset: synchronous, active low; gains to unity, crosspoints, flags and mixes to zero.
module audio_matrix_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample and command items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  amx_pkg::in_item_t                  in_data,
  // mixed output items
  output logic                               out_valid,
  input  logic                               out_ready,
  output amx_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [amx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_SETTLE, S_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic [amx_pkg::SETTLE_W-1:0] cnt_r, cnt_nxt;
  logic [amx_pkg::OUT_IW-1:0]   k_r, k_nxt;
  logic                         last_r, last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  amx_pkg::out_item_t           out_data_r, out_data_nxt;
  amx_pkg::mix_tok_t            tok_r, tok_nxt;

  // configuration registers
  logic [3:0]                   nin_r;
  logic [3:0]                   nout_r;
  logic [15:0]                  thr_r;

  // per-input settings
  logic [15:0]                  in_gain_r [amx_pkg::NUM_IN];
  logic                         in_mute_r [amx_pkg::NUM_IN];

  logic                         in_fire;
  logic                         cfg_fire;
  logic                         clr;
  logic                         in_ok;
  logic [15:0]                  gain_cl;
  logic [amx_pkg::CNT_W-1:0]    n_used;
  logic                         any_solo;
  logic                         emit_last;

  amx_pkg::mix_tok_t            tok [amx_pkg::NUM_OUT+1];
  amx_pkg::cell_wr_t            wr [amx_pkg::NUM_OUT];
  logic [amx_pkg::NUM_OUT-1:0]  mix_en;
  logic [amx_pkg::NUM_OUT-1:0]  cell_solo;
  logic signed [23:0]           cell_val [amx_pkg::NUM_OUT];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_ok    = int'(in_data.in_index) < amx_pkg::NUM_IN;
  assign gain_cl  = amx_pkg::clamp_gain(in_data.setting);
  assign any_solo = |cell_solo;

  // outputs used: register clamped to the cell count and to eight
  assign n_used = (int'(nout_r) > amx_pkg::OUT_LIM) ? amx_pkg::CNT_W'(amx_pkg::OUT_LIM)
                                                   : amx_pkg::CNT_W'(nout_r);
  assign emit_last = (amx_pkg::CNT_W'(k_r) + 1'b1) == n_used;

  always_comb begin
    for (int k = 0; k < amx_pkg::NUM_OUT; k++) begin
      mix_en[k]         = k < int'(n_used);
      wr[k].xp_we       = in_fire && (in_data.cmd == amx_pkg::CMD_XP) && in_ok
                          && (int'(in_data.out_index) == k);
      wr[k].og_we       = in_fire && (in_data.cmd == amx_pkg::CMD_OUT_GAIN)
                          && (int'(in_data.out_index) == k);
      wr[k].mute_we     = in_fire && (in_data.cmd == amx_pkg::CMD_OUT_MUTE)
                          && (int'(in_data.out_index) == k);
      wr[k].solo_we     = in_fire && (in_data.cmd == amx_pkg::CMD_SOLO)
                          && (int'(in_data.out_index) == k);
      wr[k].in_index    = in_data.in_index;
      wr[k].gain        = gain_cl;
      wr[k].flag        = in_data.setting[0];
    end
  end

  // the row: token enters cell 0 and is handed one cell on each cycle
  assign tok[0] = tok_r;

  for (genvar g = 0; g < amx_pkg::NUM_OUT; g++) begin : g_cell
    amx_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .wr       (wr[g]),
      .mix_en   (mix_en[g]),
      .thresh   (thr_r),
      .any_solo (any_solo),
      .clr      (clr),
      .solo     (cell_solo[g]),
      .out_val  (cell_val[g])
    );
  end

  // input-side settings and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nin_r  <= 4'd8;
      nout_r <= 4'd8;
      thr_r  <= '0;
      for (int i = 0; i < amx_pkg::NUM_IN; i++) begin
        in_gain_r[i] <= amx_pkg::UNITY;
        in_mute_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          amx_pkg::CFG_NUM_IN:  nin_r  <= cfg_data[3:0];
          amx_pkg::CFG_NUM_OUT: nout_r <= cfg_data[3:0];
          amx_pkg::CFG_THRESH:  thr_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_ok && (in_data.cmd == amx_pkg::CMD_IN_GAIN)) begin
        in_gain_r[in_data.in_index] <= gain_cl;
      end
      if (in_fire && in_ok && (in_data.cmd == amx_pkg::CMD_IN_MUTE)) begin
        in_mute_r[in_data.in_index] <= in_data.setting[0];
      end
    end
  end

  // sequencer: inject token, wait for the row to finish, read out at frame end
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    tok_nxt       = tok_r;
    tok_nxt.valid = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    clr           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.cmd == amx_pkg::CMD_SAMPLE)) begin
          tok_nxt.valid    = 1'b1;
          // muted or unused inputs still walk the row, but add nothing
          tok_nxt.mix      = in_ok && ({1'b0, in_data.in_index} < nin_r)
                             && !in_mute_r[in_data.in_index];
          tok_nxt.in_index = in_data.in_index;
          tok_nxt.sample   = in_data.sample;
          tok_nxt.in_gain  = in_gain_r[in_data.in_index];
          last_nxt         = in_data.last_in_frame;
          state_nxt        = S_MIX;
        end
      end
      S_MIX: begin
        if (tok[amx_pkg::NUM_OUT].valid) begin
          cnt_nxt   = amx_pkg::SETTLE_W'(amx_pkg::SETTLE_CYC - 1);
          state_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (cnt_r == '0) begin
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (n_used == '0) begin
            clr       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = '0;
            state_nxt = S_EMIT;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_channel = 3'(k_r);
          out_data_nxt.out_sample  = cell_val[k_r];
          out_data_nxt.last_output = emit_last;
          if (emit_last) begin
            clr       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
      tok_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      tok_r       <= tok_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule

/* sim/tb_audio_matrix_mixer.sv */
// Self-checking testbench for the crosspoint audio mixer: directed, register and random traffic.
module tb_audio_matrix_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import amx_pkg::*;

  // cmd 7 has no name in the package; the mixer must drop it
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // register index 3 maps to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [23:0] SMP_MAX = 24'h7FFFFF;
  localparam logic [23:0] SMP_MIN = 24'h800000;

  localparam int     GAIN_CAP = (MAX_GAIN > 65535) ? 65535 : MAX_GAIN;
  localparam longint ACC_MAX  = 2147483647;
  localparam longint ACC_MIN  = -longint'(2147483647) - 1;
  localparam longint PCM_MAX  = 8388607;
  localparam longint PCM_MIN  = -8388608;

  // a sample holds the input until its token has walked the row and settled; margin on top
  localparam int IDLE_CYC    = NUM_OUT + 6 + SETTLE_CYC + 8;
  // longest stretch without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 3000;

  // ---------------------------------------------------------------------------
  // DUT hook-up; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  audio_matrix_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the mixer state, and the queue of mixed samples still owed
  // ---------------------------------------------------------------------------
  logic [15:0] xp_lvl   [NUM_IN][NUM_OUT];
  logic [15:0] in_lvl   [NUM_IN];
  logic [15:0] out_lvl  [NUM_OUT];
  bit          in_mute  [NUM_IN];
  bit          out_mute [NUM_OUT];
  bit          out_solo [NUM_OUT];
  bit          solo_any;
  int          mix_acc  [NUM_OUT];

  logic [3:0]  ins_used;
  logic [3:0]  outs_used;
  logic [15:0] skip_level;

  out_item_t   mixed_due[$];

  int unsigned items_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned reg_sets     = 0;
  int unsigned err_count    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_run    = 0;
  bit          steady       = 1'b0;  // set: neither side idles

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [15:0] gain_clip(logic [15:0] v);
    return (v > GAIN_CAP) ? 16'(GAIN_CAP) : v;
  endfunction

  function automatic void mixer_clear();
    foreach (xp_lvl[i, o]) xp_lvl[i][o] = '0;
    foreach (in_lvl[i]) begin
      in_lvl[i]  = UNITY;
      in_mute[i] = 1'b0;
    end
    foreach (out_lvl[o]) begin
      out_lvl[o]  = UNITY;
      out_mute[o] = 1'b0;
      out_solo[o] = 1'b0;
      mix_acc[o]  = 0;
    end
    solo_any   = 1'b0;
    ins_used   = 4'd8;
    outs_used  = 4'd8;
    skip_level = '0;
  endfunction

  // Apply one accepted item to the shadow state; a frame end queues the mixed samples.
  function automatic void mix_item(in_item_t it);
    int unsigned ii, oi, n;
    logic [63:0] prod;
    longint      s, g, term, v;
    out_item_t   r;
    bit          live;
    ii = it.in_index;
    oi = it.out_index;
    n  = outs_used;
    if (n > NUM_OUT) n = NUM_OUT;
    if (n > 8) n = 8;
    case (it.cmd)
      CMD_XP:       if (ii < NUM_IN && oi < NUM_OUT) xp_lvl[ii][oi] = gain_clip(it.setting);
      CMD_IN_GAIN:  if (ii < NUM_IN) in_lvl[ii] = gain_clip(it.setting);
      CMD_OUT_GAIN: if (oi < NUM_OUT) out_lvl[oi] = gain_clip(it.setting);
      CMD_IN_MUTE:  if (ii < NUM_IN) in_mute[ii] = it.setting[0];
      CMD_OUT_MUTE: if (oi < NUM_OUT) out_mute[oi] = it.setting[0];
      CMD_SOLO: begin
        if (oi < NUM_OUT) begin
          out_solo[oi] = it.setting[0];
          solo_any = 1'b0;
          foreach (out_solo[o]) solo_any |= out_solo[o];
        end
      end
      CMD_SAMPLE: begin
        if (ii < NUM_IN && ii < ins_used && !in_mute[ii]) begin
          s = longint'(it.sample);
          for (int o = 0; o < n; o++) begin
            if (xp_lvl[ii][o] <= skip_level) continue;
            // combined gain in Q.12, rounded; then the Q1.23 term rounded half up
            prod = 64'(xp_lvl[ii][o]) * 64'(in_lvl[ii]) * 64'(out_lvl[o]) + 64'h80_0000;
            g    = longint'(prod >> 24);
            term = clip((s * g + 2048) >>> 12, ACC_MIN, ACC_MAX);
            mix_acc[o] = int'(clip(longint'(mix_acc[o]) + term, ACC_MIN, ACC_MAX));
          end
        end
        if (it.last_in_frame) begin
          for (int k = 0; k < n; k++) begin
            live = !out_mute[k] && (!solo_any || out_solo[k]);
            v    = live ? clip(longint'(mix_acc[k]), PCM_MIN, PCM_MAX) : 0;
            r.out_channel = 3'(k);
            r.out_sample  = 24'(v);
            r.last_output = (k == n - 1);
            mixed_due.push_back(r);
          end
          foreach (mix_acc[o]) mix_acc[o] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders and random picks
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // unused fields carry random bits so that they toggle too
  function automatic in_item_t make_cmd(logic [2:0] c, int unsigned ii, int unsigned oi,
                                        logic [15:0] setting);
    in_item_t it;
    it.cmd           = c;
    it.in_index      = 3'(ii);
    it.out_index     = 3'(oi);
    it.sample        = 24'($urandom);
    it.setting       = setting;
    it.last_in_frame = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_sample(int unsigned ii, logic [23:0] s, bit last);
    in_item_t it;
    it.cmd           = CMD_SAMPLE;
    it.in_index      = 3'(ii);
    it.out_index     = 3'($urandom);
    it.sample        = s;
    it.setting       = 16'($urandom);
    it.last_in_frame = last;
    return it;
  endfunction

  function automatic logic [15:0] rand_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 35) return 16'($urandom_range(3000, 5000));
    if (r < 50) return 16'($urandom_range(GAIN_CAP, 65535));  // clamps
    if (r < 60) return 16'(GAIN_CAP);
    return 16'($urandom_range(0, GAIN_CAP));
  endfunction

  function automatic logic [23:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return SMP_MAX;
    if (r < 20) return SMP_MIN;
    return 24'($urandom);
  endfunction

  // crosspoint writes are weighted up, otherwise most routes stay silent
  function automatic in_item_t rand_command();
    logic [2:0]  c;
    logic [15:0] v;
    if ($urandom_range(0, 99) < 50) c = CMD_XP;
    else c = 3'($urandom_range(CMD_IN_GAIN, CMD_SOLO));
    case (c)
      CMD_IN_MUTE, CMD_OUT_MUTE: v = {15'($urandom), 1'($urandom_range(0, 99) < 25)};
      CMD_SOLO:                  v = {15'($urandom), 1'($urandom_range(0, 99) < 15)};
      default:                   v = rand_gain();
    endcase
    return make_cmd(c, $urandom_range(0, 7), $urandom_range(0, 7), v);
  endfunction

  // anything at all, unknown command included
  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd           = 3'($urandom);
    it.in_index      = 3'($urandom);
    it.out_index     = 3'($urandom);
    it.sample        = 24'($urandom);
    it.setting       = 16'($urandom);
    it.last_in_frame = 1'($urandom);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then fold it into the shadow state.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    mix_item(it);
    items_sent++;
    if (it.cmd == CMD_SAMPLE && it.last_in_frame) frames_sent++;
  endtask

  // A few settings, then one frame of samples from random inputs.
  task automatic send_frame();
    int unsigned ncmd, nsmp;
    ncmd = $urandom_range(0, 4);
    nsmp = $urandom_range(1, 10);
    repeat (ncmd) send_item(rand_command());
    for (int k = 0; k < nsmp; k++)
      send_item(make_sample($urandom_range(0, 7), rand_sample(), k == nsmp - 1));
  endtask

  // Stop sending and wait for every owed sample; optionally let a silent item finish too.
  task automatic wait_idle(bit settle);
    in_valid <= 1'b0;
    while (mixed_due.size() != 0) @(posedge clk);
    if (settle) repeat (IDLE_CYC) @(posedge clk);
  endtask

  // Write all registers back to back; the spare index must change nothing.
  task automatic set_registers(logic [3:0] ni, logic [3:0] no, logic [15:0] th);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [15:0]          vals [4];
    idx  = '{CFG_NUM_IN, CFG_NUM_OUT, CFG_THRESH, CFG_SPARE};
    vals = '{{12'($urandom), ni}, {12'($urandom), no}, th, 16'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        CFG_NUM_IN:  ins_used   = vals[k][3:0];
        CFG_NUM_OUT: outs_used  = vals[k][3:0];
        CFG_THRESH:  skip_level = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    reg_sets++;
  endtask

  // Result side: random stalls of the same shape as the sender's gaps.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      hold_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_error(string what, longint got, longint want);
    $display("%0t ERROR %s: got %0d, wanted %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (mixed_due.size() == 0) begin
        note_error("item with none owed, channel", out_data.out_channel, -1);
      end else begin
        want = mixed_due.pop_front();
        if (out_data.out_channel !== want.out_channel)
          note_error("out_channel", out_data.out_channel, want.out_channel);
        if (out_data.out_sample !== want.out_sample)
          note_error($sformatf("out_sample ch %0d", want.out_channel),
                     longint'(out_data.out_sample), longint'(want.out_sample));
        if (out_data.last_output !== want.last_output)
          note_error($sformatf("last_output ch %0d", want.out_channel),
                     out_data.last_output, want.last_output);
      end
    end
  end

  // Hang detector: any handshake on any channel clears the count.
  initial begin
    while (quiet_run < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_run = 0;
      else
        quiet_run++;
    end
    $display("timeout: %0d cycles without an item moving", QUIET_LIMIT);
    $display("audio_matrix_mixer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset defaults, gain clamping, mutes, solo, 24- and 32-bit saturation,
  // and the items that must give nothing.
  task automatic test_directed_cases();
    in_item_t it;
    // all crosspoints zero after reset: a full frame of silence
    send_item(make_sample(0, SMP_MAX, 1'b1));
    send_item(make_cmd(CMD_XP, 0, 0, 16'hFFFF));           // clamps to the cap
    send_item(make_cmd(CMD_XP, 7, 7, UNITY));
    send_item(make_cmd(CMD_XP, 0, 1, 16'd1));              // smallest non-zero
    send_item(make_cmd(CMD_IN_GAIN, 0, $urandom_range(0, 7), 16'(GAIN_CAP)));
    send_item(make_cmd(CMD_OUT_GAIN, $urandom_range(0, 7), 0, 16'(GAIN_CAP)));
    send_item(make_sample(0, SMP_MAX, 1'b0));
    send_item(make_sample(7, SMP_MIN, 1'b0));
    send_item(make_sample(0, SMP_MIN, 1'b1));
    // muted input contributes nothing
    send_item(make_cmd(CMD_IN_MUTE, 7, $urandom_range(0, 7), 16'h0001));
    send_item(make_sample(7, SMP_MAX, 1'b1));
    send_item(make_cmd(CMD_IN_MUTE, 7, $urandom_range(0, 7), 16'hFFFE));  // flag is bit 0
    // muted output, and solo silencing everything not soloed
    send_item(make_cmd(CMD_OUT_MUTE, $urandom_range(0, 7), 7, 16'h0001));
    send_item(make_cmd(CMD_SOLO, $urandom_range(0, 7), 1, 16'h0001));
    send_item(make_sample(0, SMP_MAX, 1'b1));
    send_item(make_cmd(CMD_SOLO, $urandom_range(0, 7), 1, 16'hFFFE));
    send_item(make_cmd(CMD_OUT_MUTE, $urandom_range(0, 7), 7, 16'h0000));
    // frame mark on an unknown command and on a setting: no frame end
    it = make_cmd(CMD_UNUSED, 0, 0, 16'hFFFF);
    it.last_in_frame = 1'b1;
    send_item(it);
    it = make_cmd(CMD_XP, 0, 2, 16'hFFFF);
    it.last_in_frame = 1'b1;
    send_item(it);
    // full-scale run: out0 pins at the 32-bit limit and the negative run then
    // pulls it back down to -1; out2 stays above the 24-bit limit
    repeat (5) send_item(make_sample(0, SMP_MAX, 1'b0));
    repeat (3) send_item(make_sample(0, SMP_MIN, 1'b0));
    send_item(make_sample(0, SMP_MIN, 1'b1));
    send_item(make_sample(3, SMP_MIN, 1'b1));
    wait_idle(1'b1);
  endtask

  // Register phases, extremes first; each phase runs a few random frames.
  task automatic test_register_settings();
    logic [3:0]  ni, no;
    logic [15:0] th;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin ni = 4'd0;  no = 4'd8;  th = 16'd0;      end  // nothing mixed
        1: begin ni = 4'd15; no = 4'd15; th = 16'd0;      end  // counts above the array
        2: begin ni = 4'd8;  no = 4'd1;  th = 16'hFFFF;   end  // every route skipped
        3: begin ni = 4'd8;  no = 4'd0;  th = 16'd0;      end  // no outputs at all
        4: begin ni = 4'd1;  no = 4'd8;  th = UNITY;      end
        7: begin ni = 4'd8;  no = 4'd8;  th = 16'd0;      end  // back to reset values
        default: begin
          ni = 4'($urandom_range(0, 15));
          no = 4'($urandom_range(0, 15));
          th = 16'($urandom_range(0, 20000));
        end
      endcase
      wait_idle(1'b1);
      set_registers(ni, no, th);
      repeat (3) send_frame();
      send_item(noise_item());
    end
    wait_idle(1'b1);
  endtask

  // Mostly well-formed frames with random content, some noise, one stretch with no
  // idling and periodic pauses until the result side has caught up.
  task automatic test_random_traffic(int unsigned target);
    int unsigned frames_here;
    frames_here = 0;
    while (items_sent < target) begin
      steady = (frames_here >= 15 && frames_here < 30);
      if ($urandom_range(0, 99) < 15) begin
        send_item(noise_item());
      end else begin
        send_frame();
        frames_here++;
        if (frames_here % 20 == 10) wait_idle(1'b0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    mixer_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_cases();
    test_register_settings();
    test_random_traffic(430);

    // drain, then let any silent item finish before judging
    wait_idle(1'b1);

    $display("covered %0d items in %0d frames under %0d register settings",
             items_sent, frames_sent, reg_sets + 1);
    $display("checked %0d mixed samples, %0d errors", results_seen, err_count);
    if (err_count == 0) begin
      $display("audio_matrix_mixer: match");
    end else begin
      $display("audio_matrix_mixer: mismatch");
    end
    $finish;
  end

endmodule
